// ===== rtl/rlecrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlecrc_pkg
// shared constants and types of the rle unpacker with crc-32 check
// ----------------------------------------------------------------------------
package rlecrc_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgExpectedSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExpectedCrc  = 1'b1;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    VerdictValid    = 2'd0,
    VerdictOverflow = 2'd1,
    VerdictShort    = 2'd2,
    VerdictCrcBad   = 2'd3
  } verdict_e;

endpackage

// ===== rtl/rlecrc_in_if.sv =====
// ----------------------------------------------------------------------------
// rlecrc_in_if
// packed byte channel: valid, ready and one packed byte with its end flag
// ----------------------------------------------------------------------------
interface rlecrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_end;

  modport source (output valid, output packed_byte, output stream_end, input ready);
  modport sink   (input valid, input packed_byte, input stream_end, output ready);
endinterface

// ===== rtl/rlecrc_out_if.sv =====
// ----------------------------------------------------------------------------
// rlecrc_out_if
// result channel: valid, ready and one data or status result
// ----------------------------------------------------------------------------
interface rlecrc_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [7:0] repeat_count;
  logic [1:0] verdict;
  logic       last_result;

  modport source (output valid, output out_kind, output out_byte, output repeat_count,
                  output verdict, output last_result, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input repeat_count,
                  input verdict, input last_result, output ready);
endinterface

// ===== rtl/rlecrc_crc_step.sv =====
// ----------------------------------------------------------------------------
// rlecrc_crc_step
// one byte of reflected crc-32: xor in the byte, then eight shift steps
// ----------------------------------------------------------------------------
module rlecrc_crc_step
  import rlecrc_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

// ===== rtl/rle_unpack_with_crc32_check_unit.sv =====
// ----------------------------------------------------------------------------
// rle_unpack_with_crc32_check_unit
// packbits style rle unpacker keeping a crc-32 and byte count of the output
//
//   channel   dir  transfer when        payload
//   in_i      in   valid && ready       packed_byte, stream_end
//   out_o     out  valid && ready       out_kind, out_byte, repeat_count,
//                                       verdict, last_result
//   cfg       in   cfg_we_i high        cfg_idx_i, cfg_wdata_i
//
// a token byte is taken in idle; a literal byte passes the one shared
// byte-wide crc step once and a run value len times (len up to 128)
// before its data result; a stream end adds the status result
// one result register parts the sides; a stalled result holds the sequencer
// reset (async, active low) clears stream state and both registers
// ----------------------------------------------------------------------------
module rle_unpack_with_crc32_check_unit
  import rlecrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  rlecrc_in_if.sink          in_i,
  rlecrc_out_if.source       out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StData = 2'd2;
  localparam logic [1:0] StStat = 2'd3;

  localparam logic [1:0] PhToken   = 2'd0;
  localparam logic [1:0] PhLiteral = 2'd1;
  localparam logic [1:0] PhRunVal  = 2'd2;

  logic [31:0] exp_size_q, exp_crc_q;
  logic [31:0] crc_q, crc_d;
  logic [31:0] cnt_q, cnt_d;
  logic [7:0]  tok_q, tok_d;
  logic [1:0]  phase_q, phase_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  st_q, st_d;
  logic [7:0]  iter_q, iter_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  rep_q, rep_d;
  logic        end_q, end_d;

  logic        ov_q, ov_d;
  logic        ok_q, ok_d;
  logic [7:0]  ob_q, ob_d;
  logic [7:0]  orep_q, orep_d;
  logic [1:0]  over_q, over_d;
  logic        olast_q, olast_d;

  logic        accept, slot_free;
  logic [31:0] remaining;
  logic [31:0] crc_next;
  logic [7:0]  tok_dec;
  verdict_e    verdict;

  rlecrc_crc_step u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_q),
    .crc_o  (crc_next)
  );

  assign in_i.ready = (st_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign slot_free  = !ov_q || out_o.ready;
  assign remaining  = (cnt_q < exp_size_q) ? (exp_size_q - cnt_q) : 32'd0;
  assign tok_dec    = tok_q - 8'd1;

  always_comb begin
    if (ovf_q) begin
      verdict = VerdictOverflow;
    end else if (phase_q != PhToken || cnt_q != exp_size_q) begin
      verdict = VerdictShort;
    end else if ((crc_q ^ CrcInit) != exp_crc_q) begin
      verdict = VerdictCrcBad;
    end else begin
      verdict = VerdictValid;
    end
  end

  always_comb begin
    st_d    = st_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    tok_d   = tok_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    iter_d  = iter_q;
    byte_d  = byte_q;
    rep_d   = rep_q;
    end_d   = end_q;
    ov_d    = ov_q && !out_o.ready;
    ok_d    = ok_q;
    ob_d    = ob_q;
    orep_d  = orep_q;
    over_d  = over_q;
    olast_d = olast_q;

    case (st_q)
      StIdle: begin
        if (accept) begin
          byte_d = in_i.packed_byte;
          end_d  = in_i.stream_end;
          st_d   = in_i.stream_end ? StStat : StIdle;
          case (phase_q)
            PhToken: begin
              tok_d   = {1'b0, in_i.packed_byte[6:0]} + 8'd1;
              phase_d = in_i.packed_byte[7] ? PhRunVal : PhLiteral;
            end
            PhLiteral: begin
              if (remaining == 32'd0) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d  = cnt_q + 32'd1;
                iter_d = 8'd1;
                rep_d  = 8'd1;
                st_d   = StRun;
              end
              tok_d = tok_dec;
              if (tok_dec == 8'd0) begin
                phase_d = PhToken;
              end
            end
            default: begin
              if ({24'd0, tok_q} > remaining) begin
                ovf_d  = 1'b1;
                iter_d = remaining[7:0];
                rep_d  = remaining[7:0];
                cnt_d  = cnt_q + remaining;
              end else begin
                iter_d = tok_q;
                rep_d  = tok_q;
                cnt_d  = cnt_q + {24'd0, tok_q};
              end
              if (({24'd0, tok_q} > remaining) ? (remaining != 32'd0) : (tok_q != 8'd0)) begin
                st_d = StRun;
              end
              tok_d   = 8'd0;
              phase_d = PhToken;
            end
          endcase
        end
      end
      StRun: begin
        crc_d  = crc_next;
        iter_d = iter_q - 8'd1;
        if (iter_q == 8'd1) begin
          st_d = StData;
        end
      end
      StData: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ok_d    = KindData;
          ob_d    = byte_q;
          orep_d  = rep_q;
          over_d  = VerdictValid;
          olast_d = !end_q;
          st_d    = end_q ? StStat : StIdle;
        end
      end
      default: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ok_d    = KindStatus;
          ob_d    = 8'd0;
          orep_d  = 8'd0;
          over_d  = verdict;
          olast_d = 1'b1;
          crc_d   = CrcInit;
          cnt_d   = 32'd0;
          tok_d   = 8'd0;
          phase_d = PhToken;
          ovf_d   = 1'b0;
          st_d    = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      crc_q      <= CrcInit;
      cnt_q      <= 32'd0;
      tok_q      <= 8'd0;
      phase_q    <= PhToken;
      ovf_q      <= 1'b0;
      iter_q     <= 8'd0;
      end_q      <= 1'b0;
      ov_q       <= 1'b0;
      exp_size_q <= 32'd0;
      exp_crc_q  <= 32'd0;
    end else begin
      st_q    <= st_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      tok_q   <= tok_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
      iter_q  <= iter_d;
      end_q   <= end_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgExpectedSize: exp_size_q <= cfg_wdata_i;
          CfgExpectedCrc:  exp_crc_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    rep_q   <= rep_d;
    ok_q    <= ok_d;
    ob_q    <= ob_d;
    orep_q  <= orep_d;
    over_q  <= over_d;
    olast_q <= olast_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_kind     = ok_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.repeat_count = orep_q;
  assign out_o.verdict      = over_q;
  assign out_o.last_result  = olast_q;

  a_run_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRun |-> iter_q != 8'd0)
    else $error("crc iteration with zero count");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ok_q == KindStatus) |-> (olast_q && orep_q == 8'd0))
    else $error("status result not marked last");

  a_data_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ok_q == KindData) |-> (orep_q != 8'd0 && over_q == VerdictValid))
    else $error("data result with zero repeat or verdict");

  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StStat && slot_free) |=> (crc_q == CrcInit && cnt_q == 32'd0 &&
                                       phase_q == PhToken && !ovf_q))
    else $error("stream state not cleared after status");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> ov_q)
    else $error("pending result dropped");

endmodule

// ===== verif/rle_unpack_with_crc32_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rle_unpack_with_crc32_check_unit_tb
// self-checking bench for the rle unpacker with crc-32 check
//
// packed streams go in as directed cases and then as random well-formed,
// truncated and noise streams; the expected size and crc registers are set
// to match, to undershoot, to overshoot or to miss the crc. a scoreboard
// predicts every data and status result from each accepted packed byte and
// compares the results field by field. both channel sides idle at random
// ----------------------------------------------------------------------------
module rle_unpack_with_crc32_check_unit_tb
  import rlecrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles   = 150;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 700;

  typedef enum logic [1:0] {
    PhToken,
    PhLiteral,
    PhRunValue
  } unpack_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [7:0] count;
    verdict_e   verdict;
    logic       last;
  } rle_result_t;

  class rle_scoreboard;
    rle_result_t   expected_q[$];
    int unsigned   errors;
    logic [31:0]   size_reg;
    logic [31:0]   crc_reg;
    logic [31:0]   crc_acc;
    logic [31:0]   produced;
    logic [7:0]    run_left;
    unpack_phase_e step_phase;
    logic          overflow;

    function new();
      errors   = 0;
      size_reg = '0;
      crc_reg  = '0;
      clear_stream();
    endfunction

    static function logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    function void clear_stream();
      crc_acc    = CrcInit;
      produced   = '0;
      run_left   = '0;
      step_phase = PhToken;
      overflow   = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
      if (idx == CfgExpectedSize) begin
        size_reg = value;
      end else begin
        crc_reg = value;
      end
    endfunction

    function rle_result_t make_result(logic kind, logic [7:0] value, logic [7:0] count,
                                      verdict_e verdict);
      rle_result_t r;
      r.kind    = kind;
      r.value   = value;
      r.count   = count;
      r.verdict = verdict;
      r.last    = 1'b0;
      return r;
    endfunction

    function void note_input(logic [7:0] b, logic stream_end);
      logic [31:0] remaining;
      logic [31:0] len;
      verdict_e    v;
      rle_result_t step_q[$];
      remaining = (produced < size_reg) ? (size_reg - produced) : 32'd0;
      case (step_phase)
        PhToken: begin
          run_left   = {1'b0, b[6:0]} + 8'd1;
          step_phase = b[7] ? PhRunValue : PhLiteral;
        end
        PhLiteral: begin
          if (remaining == 0) begin
            overflow = 1'b1;
          end else begin
            crc_acc  = crc32_byte(crc_acc, b);
            produced = produced + 1;
            step_q.push_back(make_result(KindData, b, 8'd1, VerdictValid));
          end
          run_left = run_left - 8'd1;
          if (run_left == 0) begin
            step_phase = PhToken;
          end
        end
        default: begin
          len = {24'd0, run_left};
          if (len > remaining) begin
            overflow = 1'b1;
            len      = remaining;
          end
          for (int i = 0; i < len; i++) begin
            crc_acc = crc32_byte(crc_acc, b);
          end
          produced = produced + len;
          if (len != 0) begin
            step_q.push_back(make_result(KindData, b, len[7:0], VerdictValid));
          end
          run_left   = '0;
          step_phase = PhToken;
        end
      endcase
      if (stream_end) begin
        if (overflow) begin
          v = VerdictOverflow;
        end else if (step_phase != PhToken || produced != size_reg) begin
          v = VerdictShort;
        end else if ((crc_acc ^ CrcInit) != crc_reg) begin
          v = VerdictCrcBad;
        end else begin
          v = VerdictValid;
        end
        step_q.push_back(make_result(KindStatus, 8'd0, 8'd0, v));
        clear_stream();
      end
      if (step_q.size() != 0) begin
        step_q[step_q.size()-1].last = 1'b1;
      end
      foreach (step_q[i]) begin
        expected_q.push_back(step_q[i]);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(rle_result_t got);
      rle_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        compare_field("out_kind", 8'(want.kind), 8'(got.kind));
        compare_field("out_byte", want.value, got.value);
        compare_field("repeat_count", want.count, got.count);
        compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
        compare_field("last_result", 8'(want.last), 8'(got.last));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [31:0]        cfg_wdata;
  logic               calm;
  int unsigned        items_sent;
  int unsigned        idle_cycles = 0;
  logic [7:0]         stream_q[$];
  rle_result_t        seen;
  rle_scoreboard      sb;

  rlecrc_in_if  pk_if ();
  rlecrc_out_if res_if ();

  rle_unpack_with_crc32_check_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pk_if),
    .out_o       (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.kind    = res_if.out_kind;
      seen.value   = res_if.out_byte;
      seen.count   = res_if.repeat_count;
      seen.verdict = verdict_e'(res_if.verdict);
      seen.last    = res_if.last_result;
      sb.check_result(seen);
    end
    if ((pk_if.valid && pk_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic stream_end);
    if (!calm && $urandom_range(0, 99) < 20) begin
      pk_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    pk_if.valid       <= 1'b1;
    pk_if.packed_byte <= b;
    pk_if.stream_end  <= stream_end;
    @(posedge clk_i);
    while (!pk_if.ready) @(posedge clk_i);
    sb.note_input(b, stream_end);
    items_sent++;
  endtask

  task automatic send_stream(input logic with_end);
    foreach (stream_q[i]) begin
      drive_byte(stream_q[i], with_end && (i == stream_q.size() - 1));
    end
  endtask

  task automatic wait_drained();
    pk_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [31:0] size_v, input logic [31:0] crc_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgExpectedSize;
    cfg_wdata <= size_v;
    @(posedge clk_i);
    cfg_idx   <= CfgExpectedCrc;
    cfg_wdata <= crc_v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_reg(CfgExpectedSize, size_v);
    sb.set_reg(CfgExpectedCrc, crc_v);
  endtask

  // well-formed stream, or truncated, or plain noise
  task automatic gen_random_stream(output logic [31:0] total, output logic [31:0] crc_out);
    int unsigned mode;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  v;
    logic [31:0] crc_run;
    stream_q.delete();
    total   = '0;
    crc_run = CrcInit;
    mode    = $urandom_range(0, 99);
    if (mode < 5) begin
      repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          len = ($urandom_range(0, 99) < 4) ? 128 : $urandom_range(1, 8);
          stream_q.push_back(8'(len - 1));
          repeat (len) begin
            v = 8'($urandom);
            stream_q.push_back(v);
            crc_run = rle_scoreboard::crc32_byte(crc_run, v);
          end
        end else begin
          len = (pick < 54) ? 128 : (pick < 60) ? $urandom_range(17, 127)
                                               : $urandom_range(1, 16);
          v = 8'($urandom);
          stream_q.push_back(8'h80 | 8'(len - 1));
          stream_q.push_back(v);
          repeat (len) crc_run = rle_scoreboard::crc32_byte(crc_run, v);
        end
        total = total + len;
      end
      if (mode < 13) begin
        repeat ($urandom_range(1, stream_q.size() - 1)) void'(stream_q.pop_back());
      end
    end
    crc_out = crc_run ^ CrcInit;
  endtask

  initial begin : main
    logic [31:0] crc_v;
    logic [31:0] size_v;
    logic [31:0] total;
    int unsigned pick;
    sb          = new();
    items_sent  = 0;
    rst_ni      = 1'b0;
    calm        <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CfgExpectedSize;
    cfg_wdata   <= '0;
    pk_if.valid       <= 1'b0;
    pk_if.packed_byte <= '0;
    pk_if.stream_end  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // literal of one, longest run of zeros, shortest run, clean status
    crc_v = rle_scoreboard::crc32_byte(CrcInit, 8'hFF);
    repeat (128) crc_v = rle_scoreboard::crc32_byte(crc_v, 8'h00);
    crc_v = rle_scoreboard::crc32_byte(crc_v, 8'h55);
    write_regs(32'd130, crc_v ^ CrcInit);
    stream_q = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h55};
    send_stream(1'b1);

    // literal beyond size is dropped, end mid-token
    wait_drained();
    write_regs(32'd2, 32'd0);
    stream_q = '{8'h7F, 8'h01, 8'h02, 8'h03};
    send_stream(1'b1);

    // run clipped, then run clipped to nothing
    wait_drained();
    write_regs(32'd1, 32'hFFFF_FFFF);
    stream_q = '{8'h81, 8'h10, 8'h80, 8'h20};
    send_stream(1'b1);

    // size lowered below the count mid-stream
    wait_drained();
    write_regs(32'd4, 32'd0);
    stream_q = '{8'h03, 8'h01, 8'h02, 8'h03};
    send_stream(1'b0);
    wait_drained();
    write_regs(32'd1, 32'd0);
    stream_q = '{8'h80, 8'h44};
    send_stream(1'b1);

    wait_drained();
    write_regs(32'd0, 32'hFFFF_FFFF);
    stream_q = '{8'h80, 8'h99};
    send_stream(1'b1);

    wait_drained();
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stream_q = '{8'h00, 8'h7E};
    send_stream(1'b1);

    // crc mismatch
    wait_drained();
    write_regs(32'd1, 32'd0);
    stream_q = '{8'h00, 8'h33};
    send_stream(1'b1);

    while (items_sent < RandomItems + 30) begin
      calm <= (items_sent >= 300 && items_sent < 460);
      gen_random_stream(total, crc_v);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        size_v = total;
        if (pick < 12 && total != 0) begin
          size_v = total - $urandom_range(1, total);
        end else if (pick < 22) begin
          size_v = total + $urandom_range(1, 20);
        end else if (pick < 32) begin
          crc_v = crc_v ^ (32'd1 << $urandom_range(0, 31));
        end
        wait_drained();
        write_regs(size_v, crc_v);
      end
      send_stream(1'b1);
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $display("%0t %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
